[src/comment_trace_id_scanner_assert.svh]
// assertion macros for the trace id comment scanner
`ifndef COMMENT_TRACE_ID_SCANNER_ASSERT_SVH
`define COMMENT_TRACE_ID_SCANNER_ASSERT_SVH

`ifndef SYNTHESIS
`define CTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define CTS_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define CTS_ASSERT(label, prop, msg)
`define CTS_ASSERT_NEVER(label, cond, msg)
`endif

`endif

[src/cts_pkg.sv]
// shared types and constants for the trace id comment scanner
package cts_pkg;

  localparam int MaxStmtLen = 65535;
  localparam int MaxIdLen   = 128;
  localparam int ShortLen   = 13;
  localparam int PosW       = 16;
  localparam int LenW       = 8;
  localparam int KeyLen     = 9;
  localparam int CaseDiff   = 32;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChFf    = 8'h0c;
  localparam logic [7:0] ChStar  = 8'h2a;
  localparam logic [7:0] ChSlash = 8'h2f;
  localparam logic [7:0] ChComma = 8'h2c;

  localparam logic [3:0] IdxUnder = 4'd5;
  localparam logic [3:0] IdxEq    = 4'd8;

  typedef enum logic [2:0] {
    PH_SKIP,
    PH_SLASH,
    PH_MATCH,
    PH_CAPTURE,
    PH_CLOSE,
    PH_FOUND,
    PH_DEAD
  } phase_e;

  typedef struct packed {
    logic            emit;
    logic            found;
    logic [PosW-1:0] id_start;
    logic [LenW-1:0] id_length;
  } cts_res_t;

  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h74;
      4'd1:    c = 8'h72;
      4'd2:    c = 8'h61;
      4'd3:    c = 8'h63;
      4'd4:    c = 8'h65;
      4'd5:    c = 8'h5f;
      4'd6:    c = 8'h69;
      4'd7:    c = 8'h64;
      4'd8:    c = 8'h3d;
      default: c = 8'h74;
    endcase
    return c;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChLf) || (c == ChCr) || (c == ChFf);
  endfunction

endpackage

[src/cts_scan.sv]
// scan state registers, next-state logic and result formation
`include "comment_trace_id_scanner_assert.svh"

module cts_scan
  import cts_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,
  input  logic [7:0] data_i,
  input  logic       last_i,
  output cts_res_t   res_o
);

  phase_e          phase_q, phase_d;
  logic [3:0]      midx_q, midx_d;
  logic            star_q, star_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] beg_q, beg_d;
  logic [PosW-1:0] end_q, end_d;

  logic [3:0]      idx;
  logic [7:0]      want;
  logic            hit;
  logic            scan_en;
  logic [PosW-1:0] total;
  logic [PosW-1:0] span;
  logic [PosW-1:0] span_clip;

  always_comb begin
    idx  = (midx_q > IdxEq) ? 4'd0 : midx_q;
    want = key_char(idx);
    hit  = (data_i == want) ||
           ((idx != IdxUnder) && (idx != IdxEq) && (data_i == want - 8'(CaseDiff)));
  end

  always_comb begin
    phase_d = phase_q;
    midx_d  = midx_q;
    star_d  = star_q;
    beg_d   = beg_q;
    end_d   = end_q;
    scan_en = (pos_q < PosW'(MaxStmtLen));
    pos_d   = scan_en ? pos_q + PosW'(1) : pos_q;
    total   = pos_d;

    if (scan_en) begin
      case (phase_q)
        PH_SKIP: begin
          if (!is_blank(data_i)) begin
            phase_d = (data_i == ChSlash) ? PH_SLASH : PH_DEAD;
          end
        end
        PH_SLASH: begin
          phase_d = (data_i == ChStar) ? PH_MATCH : PH_DEAD;
          midx_d  = '0;
          star_d  = 1'b0;
        end
        PH_MATCH: begin
          if (star_q && data_i == ChSlash) begin
            star_d  = 1'b0;
            phase_d = PH_DEAD;
          end else if (!star_q && data_i == ChStar) begin
            midx_d = '0;
            star_d = 1'b1;
          end else begin
            star_d = 1'b0;
            if (!hit) begin
              midx_d = '0;
            end else if (idx == IdxEq) begin
              midx_d  = '0;
              phase_d = PH_CAPTURE;
              beg_d   = pos_q + PosW'(1);
            end else begin
              midx_d = idx + 4'd1;
            end
          end
        end
        PH_CAPTURE: begin
          if (is_blank(data_i) || data_i == ChComma || data_i == ChStar) begin
            if (pos_q == beg_q) begin
              phase_d = PH_DEAD;
            end else begin
              end_d   = pos_q;
              phase_d = PH_CLOSE;
              star_d  = (data_i == ChStar);
            end
          end
        end
        PH_CLOSE: begin
          if (star_q && data_i == ChSlash) begin
            phase_d = PH_FOUND;
            star_d  = 1'b0;
          end else begin
            star_d = (data_i == ChStar);
          end
        end
        default: begin
        end
      endcase
    end

    span      = end_q - beg_q;
    span_clip = (span > PosW'(MaxIdLen)) ? PosW'(MaxIdLen) : span;

    res_o.emit      = adv_i && last_i && (total > PosW'(ShortLen));
    res_o.found     = (phase_d == PH_FOUND);
    res_o.id_start  = res_o.found ? beg_q : '0;
    res_o.id_length = res_o.found ? span_clip[LenW-1:0] : '0;

    if (last_i) begin
      phase_d = PH_SKIP;
      midx_d  = '0;
      star_d  = 1'b0;
      pos_d   = '0;
      beg_d   = '0;
      end_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SKIP;
      midx_q  <= '0;
      star_q  <= 1'b0;
      pos_q   <= '0;
      beg_q   <= '0;
      end_q   <= '0;
    end else if (adv_i) begin
      phase_q <= phase_d;
      midx_q  <= midx_d;
      star_q  <= star_d;
      pos_q   <= pos_d;
      beg_q   <= beg_d;
      end_q   <= end_d;
    end
  end

  `CTS_ASSERT(a_restart_after_last, (adv_i && last_i) |=> (phase_q == PH_SKIP && pos_q == '0),
              "scan state not restarted after last byte")
  `CTS_ASSERT_NEVER(a_capture_begin, (phase_q == PH_CAPTURE && beg_q < PosW'(2)),
                    "capture with impossible id start")
  `CTS_ASSERT_NEVER(a_close_order, (phase_q == PH_CLOSE && end_q <= beg_q),
                    "id end not past id start")

endmodule

[src/comment_trace_id_scanner.sv]
// top level of the trace id comment scanner
// One byte per transaction, one transaction accepted per clock while no last byte is stalled.
// A byte waits in an input register until the scan state is updated from it, and on the last
// byte of a statement longer than 13 bytes the report lands in an output register as that
// byte leaves the input register. The output register and input register let a new byte enter
// while a report still waits; only a last byte stalls when a report is still pending. Bytes at
// offsets 65535 and beyond are neither scanned nor counted. No memory, no clearing pass after
// reset.
`include "comment_trace_id_scanner_assert.svh"

module comment_trace_id_scanner
  import cts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [7:0]  s_tdata_i,   // data_byte
  input  logic        s_tlast_i,   // last_byte
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [23:0] m_tdata_o,   // id_start[15:0], id_length[23:16]
  output logic        m_tuser_o    // found
);

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_data_q;
  logic       in_last_q;
  logic       consume;

  cts_res_t   res;

  logic            out_valid_q, out_valid_d;
  logic            out_found_q;
  logic [PosW-1:0] out_start_q;
  logic [LenW-1:0] out_len_q;

  assign consume    = in_valid_q && (!in_last_q || !out_valid_q || m_tready_i);
  assign s_tready_o = !in_valid_q || consume;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_tvalid_i && s_tready_o) begin
      in_valid_d = 1'b1;
    end else if (consume) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tvalid_i && s_tready_o) begin
      in_data_q <= s_tdata_i;
      in_last_q <= s_tlast_i;
    end
  end

  cts_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (consume),
    .data_i (in_data_q),
    .last_i (in_last_q),
    .res_o  (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res.emit) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.emit) begin
      out_found_q <= res.found;
      out_start_q <= res.id_start;
      out_len_q   <= res.id_length;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tuser_o  = out_found_q;
  assign m_tdata_o  = {out_len_q, out_start_q};

  `CTS_ASSERT(a_report_source, $rose(m_tvalid_o) |-> $past(consume && in_last_q),
              "report without a consumed last byte")
  `CTS_ASSERT_NEVER(a_found_len, (m_tvalid_o && m_tuser_o && out_len_q == '0),
                    "found report with empty id")
  `CTS_ASSERT_NEVER(a_miss_zero, (m_tvalid_o && !m_tuser_o && (out_len_q != '0 || out_start_q != '0)),
                    "miss report with nonzero fields")

endmodule

[tb/trace_id_report_checker.sv]
// checker that predicts the scanner's trace id reports and compares them with the outputs
`timescale 1ns / 1ps

module trace_id_report_checker
  import cts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,
  input  logic        s_tlast_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [23:0] m_tdata_i,   // id_start[15:0], id_length[23:16]
  input  logic        m_tuser_i,   // found
  output int          pending_o,
  output int          fail_count_o,
  output int          stmt_count_o,
  output int          report_count_o,
  output int          found_count_o
);

  localparam logic [8*KeyLen-1:0] KEY_TEXT = {"trace_", "id="};

  typedef struct packed {
    logic            found;
    logic [PosW-1:0] id_start;
    logic [LenW-1:0] id_length;
  } report_t;

  report_t     expected_reports[$];
  phase_e      scan_phase;
  logic [3:0]  key_pos;
  logic        star_seen;
  int unsigned stmt_pos;
  int unsigned id_first;
  int unsigned id_stop;
  int          mismatches = 0;
  int          stmts      = 0;
  int          reports    = 0;
  int          found_ids  = 0;

  assign fail_count_o   = mismatches;
  assign stmt_count_o   = stmts;
  assign report_count_o = reports;
  assign found_count_o  = found_ids;

  function automatic logic [7:0] key_byte(input logic [3:0] idx);
    return KEY_TEXT[8*(KeyLen-1-int'(idx)) +: 8];
  endfunction

  function automatic logic is_space_byte(input logic [7:0] c);
    return c inside {ChSpace, ChTab, ChLf, ChCr, ChFf};
  endfunction

  function automatic logic ends_trace_id(input logic [7:0] c);
    return is_space_byte(c) || (c == ChComma) || (c == ChStar);
  endfunction

  task automatic clear_scan();
    scan_phase = PH_SKIP;
    key_pos    = '0;
    star_seen  = 1'b0;
    stmt_pos   = 0;
    id_first   = 0;
    id_stop    = 0;
  endtask

  // a miss restarts the key without trying the same byte as a t
  task automatic match_key(input logic [7:0] c, input int unsigned pos);
    logic [3:0] idx;
    logic [7:0] want;
    logic       hit;
    idx  = (key_pos > IdxEq) ? 4'd0 : key_pos;
    want = key_byte(idx);
    hit  = (c == want) || ((idx != IdxUnder) && (idx != IdxEq) && (c == want - 8'(CaseDiff)));
    if (!hit) begin
      key_pos = '0;
    end else if (idx == IdxEq) begin
      key_pos    = '0;
      scan_phase = PH_CAPTURE;
      id_first   = pos + 1;
    end else begin
      key_pos = idx + 4'd1;
    end
  endtask

  task automatic scan_step(input logic [7:0] c, input int unsigned pos);
    case (scan_phase)
      PH_SKIP: begin
        if (!is_space_byte(c)) scan_phase = (c == ChSlash) ? PH_SLASH : PH_DEAD;
      end
      PH_SLASH: begin
        scan_phase = (c == ChStar) ? PH_MATCH : PH_DEAD;
        key_pos    = '0;
        star_seen  = 1'b0;
      end
      PH_MATCH: begin
        if (star_seen) begin
          star_seen = 1'b0;
          if (c == ChSlash) scan_phase = PH_DEAD;
          else match_key(c, pos);
        end else if (c == ChStar) begin
          key_pos   = '0;
          star_seen = 1'b1;
        end else begin
          match_key(c, pos);
        end
      end
      PH_CAPTURE: begin
        if (ends_trace_id(c)) begin
          if (pos == id_first) begin
            scan_phase = PH_DEAD;
          end else begin
            id_stop    = pos;
            scan_phase = PH_CLOSE;
            star_seen  = (c == ChStar);
          end
        end
      end
      PH_CLOSE: begin
        if (star_seen && (c == ChSlash)) begin
          scan_phase = PH_FOUND;
          star_seen  = 1'b0;
        end else begin
          star_seen = (c == ChStar);
        end
      end
      default: ;
    endcase
  endtask

  task automatic take_byte(input logic [7:0] c, input logic last);
    int unsigned n;
    report_t     r;
    if (stmt_pos < MaxStmtLen) begin
      scan_step(c, stmt_pos);
      stmt_pos++;
    end
    if (last) begin
      stmts++;
      if (stmt_pos > ShortLen) begin
        r = '0;
        if (scan_phase == PH_FOUND) begin
          n = id_stop - id_first;
          if (n > MaxIdLen) n = MaxIdLen;
          r.found     = 1'b1;
          r.id_start  = id_first[PosW-1:0];
          r.id_length = n[LenW-1:0];
        end
        expected_reports = {expected_reports, r};
      end
      clear_scan();
    end
  endtask

  task automatic check_report(input report_t got);
    report_t want;
    if (expected_reports.size() == 0) begin
      $error("unexpected report: found %0d, id_start %0d, id_length %0d",
             got.found, got.id_start, got.id_length);
      mismatches++;
    end else begin
      want = expected_reports.pop_front();
      reports++;
      if (want.found) found_ids++;
      if (got.found !== want.found) begin
        $error("found: expected %0d, got %0d", want.found, got.found);
        mismatches++;
      end
      if (got.id_start !== want.id_start) begin
        $error("id_start: expected %0d, got %0d", want.id_start, got.id_start);
        mismatches++;
      end
      if (got.id_length !== want.id_length) begin
        $error("id_length: expected %0d, got %0d", want.id_length, got.id_length);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_scan();
      expected_reports.delete();
      pending_o <= 0;
    end else begin
      if (s_tvalid_i && s_tready_i) take_byte(s_tdata_i, s_tlast_i);
      if (m_tvalid_i && m_tready_i) check_report({m_tuser_i, m_tdata_i[15:0], m_tdata_i[23:16]});
      pending_o <= expected_reports.size();
    end
  end

endmodule

[tb/tb_top.sv]
// testbench top for the trace id comment scanner: stimulus, idling and verdict
`timescale 1ns / 1ps

module tb_top;
  import cts_pkg::*;

  localparam int    TotalBytes = 1850;
  localparam string KeyText    = {"trace_", "id="};

  typedef enum int {
    READY_ALWAYS,
    READY_HALF,
    READY_SPARSE,
    READY_MOSTLY
  } ready_mode_e;

  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        s_tvalid_i = 1'b0;
  logic        s_tready_o;
  logic [7:0]  s_tdata_i  = '0;
  logic        s_tlast_i  = 1'b0;
  logic        m_tvalid_o;
  logic        m_tready_i = 1'b0;
  logic [23:0] m_tdata_o;
  logic        m_tuser_o;

  int          pending_reports;
  int          fail_count;
  int          stmt_count;
  int          report_count;
  int          found_count;
  int          bytes_sent = 0;
  int          burst_left = 0;
  bit          calm       = 1'b0;
  logic [7:0]  stmt_text[$];
  ready_mode_e ready_mode = READY_ALWAYS;
  int          ready_span = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  comment_trace_id_scanner i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tlast_i  (s_tlast_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o)
  );

  trace_id_report_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_tvalid_i     (s_tvalid_i),
    .s_tready_i     (s_tready_o),
    .s_tdata_i      (s_tdata_i),
    .s_tlast_i      (s_tlast_i),
    .m_tvalid_i     (m_tvalid_o),
    .m_tready_i     (m_tready_i),
    .m_tdata_i      (m_tdata_o),
    .m_tuser_i      (m_tuser_o),
    .pending_o      (pending_reports),
    .fail_count_o   (fail_count),
    .stmt_count_o   (stmt_count),
    .report_count_o (report_count),
    .found_count_o  (found_count)
  );

  // receiver stalls follow a mode that is chosen anew at random when its span runs out
  always @(posedge clk_i) begin
    if (ready_span == 0) begin
      ready_mode <= ready_mode_e'($urandom_range(0, 3));
      ready_span <= $urandom_range(8, 80);
    end else begin
      ready_span <= ready_span - 1;
    end
    case (ready_mode)
      READY_ALWAYS: m_tready_i <= 1'b1;
      READY_HALF:   m_tready_i <= 1'($urandom_range(0, 1));
      READY_SPARSE: m_tready_i <= ($urandom_range(0, 3) == 0);
      default:      m_tready_i <= ($urandom_range(0, 7) != 0);
    endcase
  end

  task automatic put_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        s_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= b;
    s_tlast_i  <= last;
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_statement();
    for (int i = 0; i < stmt_text.size(); i++) put_byte(stmt_text[i], i == stmt_text.size() - 1);
    stmt_text.delete();
  endtask

  task automatic wait_drained();
    s_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_reports != 0) @(posedge clk_i);
  endtask

  task automatic add_byte(input logic [7:0] c);
    stmt_text = {stmt_text, c};
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic add_repeat(input logic [7:0] c, input int n);
    repeat (n) add_byte(c);
  endtask

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 4))
      0:       return ChSpace;
      1:       return ChTab;
      2:       return ChLf;
      3:       return ChCr;
      default: return ChFf;
    endcase
  endfunction

  function automatic logic [7:0] pick_terminator();
    case ($urandom_range(0, 2))
      0:       return ChComma;
      1:       return ChStar;
      default: return pick_blank();
    endcase
  endfunction

  function automatic logic [7:0] pick_id_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c inside {ChSpace, ChTab, ChLf, ChCr, ChFf, ChComma, ChStar});
    return c;
  endfunction

  function automatic logic [7:0] pick_filler();
    case ($urandom_range(0, 9))
      0:       return ChStar;
      1:       return pick_blank();
      2, 3:    return 8'($urandom_range(0, 255));
      4:       return "t";
      default: return 8'($urandom_range(8'h61, 8'h7a));
    endcase
  endfunction

  // key with random letter case; a spoiled key has one byte changed or a star put in
  task automatic add_key(input bit spoil);
    string      key;
    int         bad_at;
    logic [7:0] c;
    key    = KeyText;
    bad_at = spoil ? $urandom_range(0, key.len() - 1) : -1;
    for (int i = 0; i < key.len(); i++) begin
      c = key[i];
      if ((c >= "a") && (c <= "z") && ($urandom_range(0, 1) == 1)) c = c - 8'(CaseDiff);
      if (i == bad_at) begin
        case ($urandom_range(0, 2))
          0:       c = 8'($urandom_range(0, 255));
          1:       add_byte(ChStar);
          default: c = c ^ 8'h20;
        endcase
      end
      add_byte(c);
    end
  endtask

  task automatic build_random_statement();
    int shape;
    int id_len;
    shape = $urandom_range(0, 99);
    if (shape < 10) begin
      repeat ($urandom_range(1, 13)) add_byte(pick_filler());
    end else if (shape < 20) begin
      repeat ($urandom_range(14, 40)) add_byte(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 3)) add_byte(pick_blank());
      add_text("/*");
      repeat ($urandom_range(0, 6)) add_byte(pick_filler());
      if ($urandom_range(0, 4) == 0) begin
        add_key(1'b1);
        repeat ($urandom_range(0, 2)) add_byte(pick_filler());
      end
      add_key($urandom_range(0, 9) == 0);
      case ($urandom_range(0, 19))
        0, 1:    id_len = 0;
        2:       id_len = $urandom_range(100, 260);
        3, 4:    id_len = $urandom_range(13, 40);
        default: id_len = $urandom_range(1, 12);
      endcase
      repeat (id_len) add_byte(pick_id_byte());
      if ($urandom_range(0, 9) != 0) add_byte(pick_terminator());
      repeat ($urandom_range(0, 5)) add_byte(pick_filler());
      case ($urandom_range(0, 9))
        0:       ;
        1:       add_text("**/");
        2:       add_text("* /");
        default: add_text("*/");
      endcase
      repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(0, 255)));
      if (shape >= 90) begin
        stmt_text[$urandom_range(0, stmt_text.size() - 1)] = 8'($urandom_range(0, 255));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_text({"/*", KeyText, "abc*/select"});
    send_statement();
    stmt_text = {ChSpace, ChTab, ChLf, ChCr, ChFf};
    add_text({"/*", KeyText.toupper(), "Zz9,x*/ ;"});
    send_statement();
    add_text({"/*", KeyText, "*/"});
    send_statement();
    add_text({"/*", KeyText, "a*/"});
    send_statement();
    add_text({"/*", KeyText, " q*/ x"});
    send_statement();
    add_text({"/*t", KeyText, "ab*/xx"});
    send_statement();
    add_text("/*trace*/_id=ab*/x");
    send_statement();
    add_text({"/*tr**/", KeyText, "ab*/"});
    send_statement();
    add_text("/*TRACE-ID=ab*/xxxx");
    send_statement();
    add_text({"/*", KeyText.substr(0, 7), "+ab*/xxxx"});
    send_statement();
    add_text({"/*", KeyText, "ab ***/"});
    send_statement();
    add_text({"/*", KeyText, "abc   end"});
    send_statement();
    add_text({"select /*", KeyText, "a*/"});
    send_statement();
    add_text({"/ *", KeyText, "ab*/x"});
    send_statement();
    add_text({"/*xxxxx ", KeyText});
    send_statement();
    add_text({"/*", KeyText});
    add_repeat("k", 200);
    add_text("*/");
    send_statement();
    wait_drained();

    while (bytes_sent < TotalBytes) begin
      calm = ($urandom_range(0, 7) == 0);
      build_random_statement();
      send_statement();
      if ($urandom_range(0, 19) == 0) wait_drained();
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("sent %0d statements in %0d bytes with sender gaps and receiver stalls",
             stmt_count, bytes_sent);
    $display("checked %0d reports, %0d of them with a closed trace id", report_count,
             found_count);
    if ((fail_count == 0) && (pending_reports == 0)) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
